FILE: rtl/integer_to_base_digits_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integer to base digits block.
// Each macro expands to one labelled concurrent assertion on the given
// clock, disabled while the given active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_BASE_DIGITS_ASSERT_SVH
`define INTEGER_TO_BASE_DIGITS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/itbd_pkg.sv
// ---------------------------------------------------------------------------
// itbd_pkg
// Shared types, constants and helpers of the integer to base digits block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itbd_pkg;

	// Default width of the input value.
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// Radix register.
	localparam int unsigned RADIX_W = 5;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;

	// One digit in any supported base fits in four bits.
	localparam int unsigned DIGIT_W = 4;

	// ASCII codes.
	localparam int unsigned CHAR_W = 7;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] ASCII_NUL   = 7'h00;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_DIGITS,
		ST_BAD
	} itbd_state_t;

	// Commands to the serial divider.
	typedef struct packed {
		logic load;
		logic go;
	} itbd_div_ctl_t;

	// Status from the serial divider.
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] digit;
		logic               zero;
	} itbd_div_sts_t;

	// Maps a digit value to its character, 0-9 then A-F.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < 4'd10) begin
			res = ASCII_ZERO + CHAR_W'(d);
		end else begin
			res = ASCII_A + CHAR_W'(d - 4'd10);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/itbd_serial_div.sv
// ---------------------------------------------------------------------------
// itbd_serial_div
// Bit-serial restoring divider: divides the held value by the radix, one
// quotient bit per cycle, leaving the quotient in place for the next digit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itbd_serial_div #(
	parameter int unsigned VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  itbd_pkg::itbd_div_ctl_t       ctl,
	input  logic [VALUE_WIDTH-1:0]        mag,
	input  logic [itbd_pkg::RADIX_W-1:0]  radix,
	output itbd_pkg::itbd_div_sts_t       sts
);
	import itbd_pkg::*;

	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;

	logic [RADIX_W-1:0]     trial;
	logic [RADIX_W-1:0]     diff;
	logic                   fits;
	logic [DIGIT_W-1:0]     rem_d;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	always_comb begin
		trial = {rem_q, quo_q[VALUE_WIDTH-1]};
		fits  = (trial >= radix);
		diff  = trial - radix;
		rem_d = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load || ctl.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend/quotient shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= mag;
			rem_q <= '0;
		end else if (ctl.go) begin
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= rem_d;
		end
	end

	assign sts.done  = done_q;
	assign sts.digit = rem_q;
	assign sts.zero  = (quo_q == '0);

endmodule

`default_nettype wire

FILE: rtl/integer_to_base_digits.sv
// ---------------------------------------------------------------------------
// integer_to_base_digits
// Converts a two's complement integer to ASCII text in a base from 2 to 16.
// ---------------------------------------------------------------------------
// Usage: an item on the input channel (in_valid/in_ready, field value) is a
// number; the output channel (out_valid/out_ready) delivers one item per
// character, most significant digit first, with last set on the final one.
// A minus sign leads only in base 10. A radix outside 2..16 yields a single
// item with character NUL (code 0), last and bad_radix set. The radix must
// be written through cfg_wr_en/cfg_wr_data only while the block is idle,
// which the block itself does not enforce; the radix resets to 10. The
// digits are found least significant first by a bit-serial divider, pushed
// on a digit stack and then popped one per cycle while the receiver does
// not stall. One item is in work at a time; in_ready is high only while
// the block is idle. A stalled receiver holds the output register and the
// stack; the last character may wait while the next number is converting.
// Reset empties the stack, clears the output valid flag and restores radix.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_base_digits #(
	parameter int unsigned VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [itbd_pkg::RADIX_W-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [itbd_pkg::CHAR_W-1:0]   character,
	output logic                          last,
	output logic                          bad_radix
);
	import itbd_pkg::*;

	localparam int unsigned DEPTH_W = $clog2(VALUE_WIDTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(VALUE_WIDTH);

	itbd_state_t state_q, state_d;

	logic [RADIX_W-1:0]     radix_q;
	logic                   sign_q;
	logic [DIGIT_W-1:0]     stk_q [VALUE_WIDTH];
	logic [DEPTH_W-1:0]     depth_q;

	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   bad_q;

	logic                   accept;
	logic                   radix_bad;
	logic                   out_free;
	logic [VALUE_WIDTH-1:0] value_u;
	logic                   negative;
	logic [VALUE_WIDTH-1:0] mag_d;

	itbd_div_ctl_t          div_ctl;
	itbd_div_sts_t          div_sts;
	logic                   push;
	logic                   pop;
	logic                   out_load;
	logic [CHAR_W-1:0]      char_d;
	logic                   last_d;
	logic                   bad_d;

	// Input decode: sign, magnitude and radix check.
	always_comb begin
		value_u   = value;
		negative  = value_u[VALUE_WIDTH-1];
		mag_d     = negative ? ((~value_u) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_u;
		radix_bad = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
		accept    = in_valid && in_ready;
		out_free  = !out_valid_q || out_ready;
	end

	// Serial divider producing one digit per pass.
	itbd_serial_div #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.mag    (mag_d),
		.radix  (radix_q),
		.sts    (div_sts)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = radix_bad ? ST_BAD : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done && div_sts.zero) begin
					state_d = sign_q ? ST_SIGN : ST_DIGITS;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (out_free && (depth_q == DEPTH_ONE)) begin
					state_d = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of each state.
	always_comb begin
		in_ready    = 1'b0;
		div_ctl     = '0;
		push        = 1'b0;
		pop         = 1'b0;
		out_load    = 1'b0;
		char_d      = ASCII_NUL;
		last_d      = 1'b0;
		bad_d       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				div_ctl.load = accept && !radix_bad;
			end
			ST_DIV: begin
				push       = div_sts.done;
				div_ctl.go = div_sts.done && !div_sts.zero;
			end
			ST_SIGN: begin
				out_load = out_free;
				char_d   = ASCII_MINUS;
			end
			ST_DIGITS: begin
				out_load = out_free;
				pop      = out_free;
				char_d   = digit_char(stk_q[0]);
				last_d   = (depth_q == DEPTH_ONE);
			end
			ST_BAD: begin
				out_load = out_free;
				char_d   = ASCII_NUL;
				last_d   = 1'b1;
				bad_d    = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State, radix register, sign flag and stack depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			radix_q <= RADIX_RESET;
			sign_q  <= 1'b0;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				radix_q <= cfg_wr_data;
			end
			if (accept) begin
				sign_q <= negative && (radix_q == RADIX_DEC);
			end
			if (push) begin
				depth_q <= depth_q + 1'b1;
			end else if (pop) begin
				depth_q <= depth_q - 1'b1;
			end
		end
	end

	// Digit stack: digits enter at the top and leave from the top.
	always_ff @(posedge clk) begin
		for (int i = 0; i < VALUE_WIDTH; i++) begin
			if (push) begin
				stk_q[i] <= (i == 0) ? div_sts.digit : stk_q[(i == 0) ? 0 : i - 1];
			end else if (pop && (i < VALUE_WIDTH - 1)) begin
				stk_q[i] <= stk_q[(i < VALUE_WIDTH - 1) ? i + 1 : i];
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= char_d;
			last_q <= last_d;
			bad_q  <= bad_d;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

	// Checks on the controller and the digit stack.
`include "integer_to_base_digits_assert.svh"

	`ITBD_ASSERT_SAME(a_idle_stack_empty, clk, arst_n, in_ready, depth_q == '0, "stack not empty when idle")
	`ITBD_ASSERT_SAME(a_push_room, clk, arst_n, push, depth_q < DEPTH_MAX, "digit stack overflow")
	`ITBD_ASSERT_NEXT(a_bad_radix_path, clk, arst_n, accept && radix_bad, state_q == ST_BAD, "bad radix not reported")
	`ITBD_ASSERT_SAME(a_bad_is_last, clk, arst_n, out_valid && bad_radix, last, "error item not marked last")

endmodule

`default_nettype wire
